>>> sv/swfb_pkg.sv
// shared types, constants and check functions for the single-wire bus frame builder
package swfb_pkg;

	localparam int unsigned DEV_W   = 4;
	localparam int unsigned CMD_W   = 3;
	localparam int unsigned ADDR_W  = 5;
	localparam int unsigned DATA_W  = 8;
	localparam int unsigned HCHK_W  = 5;
	localparam int unsigned DCHK_W  = 4;
	localparam int unsigned FRAME_W = 32;
	localparam int unsigned HDR_W   = DEV_W + CMD_W + ADDR_W;

	// command codes carried in the header
	localparam logic [CMD_W-1:0] CMD_READ  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_WRITE = 3'd4;

	// mode codes of a request
	localparam logic MODE_READ  = 1'b0;
	localparam logic MODE_WRITE = 1'b1;

	// generator polynomials, top term implied
	localparam logic [HCHK_W-1:0] HDR_POLY  = 5'h05;
	localparam logic [DCHK_W-1:0] DATA_POLY = 4'h3;

	localparam logic [DEV_W-1:0] DEVICE_ID_RESET = 4'd6;

	typedef struct packed {
		logic              mode;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] wdata;
	} req_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic [HCHK_W-1:0]  header_check;
		logic [DCHK_W-1:0]  data_check;
	} rsp_t;

	// header check: header * x^5 mod x^5 + x^2 + 1, msb first
	function automatic logic [HCHK_W-1:0] hdr_check(input logic [HDR_W-1:0] hdr);
		logic [HCHK_W-1:0] rem;
		logic              top;
		rem = '0;
		for (int i = HDR_W - 1; i >= 0; i--) begin
			top = rem[HCHK_W-1];
			rem = {rem[HCHK_W-2:0], 1'b0};
			if (top ^ hdr[i]) begin
				rem = rem ^ HDR_POLY;
			end
		end
		return rem;
	endfunction

	// data check: data * x^4 mod x^4 + x + 1, msb first
	function automatic logic [DCHK_W-1:0] data_check(input logic [DATA_W-1:0] data);
		logic [DCHK_W-1:0] rem;
		logic              top;
		rem = '0;
		for (int i = DATA_W - 1; i >= 0; i--) begin
			top = rem[DCHK_W-1];
			rem = {rem[DCHK_W-2:0], 1'b0};
			if (top ^ data[i]) begin
				rem = rem ^ DATA_POLY;
			end
		end
		return rem;
	endfunction

endpackage

>>> sv/swfb_if.sv
// request, response and configuration channel interfaces
interface swfb_req_if;
	logic                             valid;
	logic                             ready;
	logic                             mode;
	logic [swfb_pkg::ADDR_W-1:0]      addr;
	logic [swfb_pkg::DATA_W-1:0]      wdata;

	modport source (output valid, output mode, output addr, output wdata,
		input ready);
	modport sink (input valid, input mode, input addr, input wdata,
		output ready);
endinterface

interface swfb_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [swfb_pkg::FRAME_W-1:0]     frame;
	logic [swfb_pkg::HCHK_W-1:0]      header_check;
	logic [swfb_pkg::DCHK_W-1:0]      data_check;

	modport source (output valid, output frame, output header_check, output data_check,
		input ready);
	modport sink (input valid, input frame, input header_check, input data_check,
		output ready);
endinterface

interface swfb_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [swfb_pkg::DEV_W-1:0]       data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/swfb_encode.sv
// header assembly, check computation and frame packing
module swfb_encode (
	input  logic [swfb_pkg::DEV_W-1:0] device_id,
	input  swfb_pkg::req_t             req,
	output swfb_pkg::rsp_t             rsp
);

	logic [swfb_pkg::CMD_W-1:0]  cmd;
	logic [swfb_pkg::HDR_W-1:0]  hdr;
	logic [swfb_pkg::HCHK_W-1:0] hchk;
	logic [swfb_pkg::DCHK_W-1:0] dchk;
	logic                        is_write;

	// header fields
	assign is_write = (req.mode == swfb_pkg::MODE_WRITE);
	assign cmd      = is_write ? swfb_pkg::CMD_WRITE : swfb_pkg::CMD_READ;
	assign hdr      = {device_id, cmd, req.addr};

	// checks, data check zero on reads
	assign hchk = swfb_pkg::hdr_check(hdr);
	assign dchk = is_write ? swfb_pkg::data_check(req.wdata) : '0;

	// msb-first packing, tail zero-padded
	always_comb begin
		rsp.header_check = hchk;
		rsp.data_check   = dchk;
		if (is_write) begin
			rsp.frame = {hdr, hchk, req.wdata, dchk, 3'b000};
		end else begin
			rsp.frame = {hdr, hchk, 15'd0};
		end
	end

endmodule

>>> sv/single_wire_bus_frame_builder_core.sv
// top level of the single-wire bus command frame builder
//
// channels: req takes one read or write request per beat (mode, addr,
// wdata); rsp delivers one packed frame per request with its header
// and data checks; cfg writes the 4-bit device id placed in every header.
// cfg is always ready and should only be written while no request is in
// flight.
// pipeline: two register stages sit between the channels (request register,
// then result register); a request accepted on req is captured in the request
// register, and its frame in the result register that drives rsp.
// throughput: one request per cycle, sustained while rsp is ready, set by the
// single pass of check and packing logic between the two registers.
// stall: when rsp is not ready the result register holds its beat; the
// request register can still fill, and req ready drops only when both
// stages are full.
// reset: arst_n clears both stage valids and restores device id 6.
module single_wire_bus_frame_builder_core (
	input  logic        clk,
	input  logic        arst_n,
	swfb_cfg_if.sink    cfg,
	swfb_req_if.sink    req,
	swfb_rsp_if.source  rsp
);

	logic [swfb_pkg::DEV_W-1:0] device_id_q;
	logic                       valid_s1;
	swfb_pkg::req_t             req_s1;
	logic                       valid_s2;
	swfb_pkg::rsp_t             rsp_s2;
	swfb_pkg::rsp_t             enc_rsp;
	logic                       adv_s2;
	logic                       take_s1;

	// configuration register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q <= swfb_pkg::DEVICE_ID_RESET;
		end else if (cfg.valid) begin
			device_id_q <= cfg.data;
		end
	end

	// stage flow control
	assign adv_s2    = !valid_s2 || rsp.ready;
	assign req.ready = !valid_s1 || adv_s2;
	assign take_s1   = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_s1) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// request register
	always_ff @(posedge clk) begin
		if (take_s1) begin
			req_s1.mode  <= req.mode;
			req_s1.addr  <= req.addr;
			req_s1.wdata <= req.wdata;
		end
	end

	swfb_encode u_encode (
		.device_id (device_id_q),
		.req       (req_s1),
		.rsp       (enc_rsp)
	);

	// result register
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			rsp_s2 <= enc_rsp;
		end
	end

	assign rsp.valid        = valid_s2;
	assign rsp.frame        = rsp_s2.frame;
	assign rsp.header_check = rsp_s2.header_check;
	assign rsp.data_check   = rsp_s2.data_check;

endmodule

>>> sv/swfb_checker.sv
// port-level checker for the frame builder, bound to the top level
module swfb_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [swfb_pkg::FRAME_W-1:0]  rsp_frame,
	input logic [swfb_pkg::HCHK_W-1:0]   rsp_header_check,
	input logic [swfb_pkg::DCHK_W-1:0]   rsp_data_check
);

	// stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame))
		else $error("stalled response beat changed");

	// header check sits in the frame right after the header
	a_hchk_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_frame[19:15] == rsp_header_check)
		else $error("header check field mismatch");

	// command field is read or write
	a_cmd_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_frame[27:25] == swfb_pkg::CMD_READ
			|| rsp_frame[27:25] == swfb_pkg::CMD_WRITE))
		else $error("bad command code in frame");

	// read frame ends after the header check
	a_read_tail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_frame[27:25] == swfb_pkg::CMD_READ
		|-> rsp_frame[14:0] == 15'd0 && rsp_data_check == '0)
		else $error("read frame tail not zero");

	// write frame carries its data check and zero pad
	a_write_tail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_frame[27:25] == swfb_pkg::CMD_WRITE
		|-> rsp_frame[6:3] == rsp_data_check && rsp_frame[2:0] == 3'd0)
		else $error("write frame data check mismatch");

endmodule

bind single_wire_bus_frame_builder_core swfb_checker u_swfb_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_frame        (rsp.frame),
	.rsp_header_check (rsp.header_check),
	.rsp_data_check   (rsp.data_check)
);

>>> test/single_wire_bus_frame_builder_core_test.sv
// self-checking testbench for the single-wire bus frame builder core
module single_wire_bus_frame_builder_core_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD  = 20;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ITEMS = 256;

	logic clk = 1'b0;
	logic arst_n;

	swfb_cfg_if cfg_bus ();
	swfb_req_if req_bus ();
	swfb_rsp_if rsp_bus ();

	single_wire_bus_frame_builder_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	// frames predicted for accepted requests, oldest first
	swfb_pkg::rsp_t             pending_frames[$];
	logic [swfb_pkg::DEV_W-1:0] device_id_shadow = swfb_pkg::DEVICE_ID_RESET;
	int                         mismatch_count = 0;
	int                         send_idle_pct = 0;
	int                         recv_stall_pct = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	// remainder of a pre-shifted dividend by a generator of degree deg
	function automatic logic [4:0] poly_remainder(input logic [31:0] dividend, input int msb,
		input logic [5:0] generator, input int deg);
		logic [31:0] rem;
		rem = dividend;
		for (int b = msb; b >= deg; b--) begin
			if (rem[b]) begin
				rem = rem ^ (32'(generator) << (b - deg));
			end
		end
		return rem[4:0];
	endfunction

	// expected frame for one request under the given device id
	function automatic swfb_pkg::rsp_t build_frame(input swfb_pkg::req_t item,
		input logic [swfb_pkg::DEV_W-1:0] dev_id);
		swfb_pkg::rsp_t             res;
		logic [swfb_pkg::HDR_W-1:0] hdr;
		logic [swfb_pkg::CMD_W-1:0] cmd;
		cmd = (item.mode == swfb_pkg::MODE_WRITE) ? swfb_pkg::CMD_WRITE
			: swfb_pkg::CMD_READ;
		hdr = {dev_id, cmd, item.addr};
		res.header_check = poly_remainder({15'd0, hdr, 5'd0},
			swfb_pkg::HDR_W + swfb_pkg::HCHK_W - 1, {1'b1, swfb_pkg::HDR_POLY},
			swfb_pkg::HCHK_W);
		res.data_check = '0;
		res.frame = {hdr, res.header_check, 15'd0};
		if (item.mode == swfb_pkg::MODE_WRITE) begin
			res.data_check = swfb_pkg::DCHK_W'(poly_remainder({20'd0, item.wdata, 4'd0},
				swfb_pkg::DATA_W + swfb_pkg::DCHK_W - 1, {2'b01, swfb_pkg::DATA_POLY},
				swfb_pkg::DCHK_W));
			res.frame[14:7] = item.wdata;
			res.frame[6:3] = res.data_check;
		end
		return res;
	endfunction

	function automatic swfb_pkg::req_t make_request(input logic mode,
		input logic [swfb_pkg::ADDR_W-1:0] addr, input logic [swfb_pkg::DATA_W-1:0] data);
		swfb_pkg::req_t item;
		item.mode = mode;
		item.addr = addr;
		item.wdata = data;
		return item;
	endfunction

	// random request, now and then pinned to the field extremes
	function automatic swfb_pkg::req_t random_request();
		swfb_pkg::req_t item;
		item = make_request(1'($urandom_range(1)), swfb_pkg::ADDR_W'($urandom_range(31)),
			swfb_pkg::DATA_W'($urandom_range(255)));
		if ($urandom_range(7) == 0) begin
			item.addr = $urandom_range(1) ? '1 : '0;
			item.wdata = $urandom_range(1) ? '1 : '0;
		end
		return item;
	endfunction

	// one request beat, with random idle cycles ahead of it
	task automatic send_request(input swfb_pkg::req_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			req_bus.valid <= 1'b0;
			req_bus.mode <= 1'($urandom_range(1));
			req_bus.addr <= swfb_pkg::ADDR_W'($urandom_range(31));
			req_bus.wdata <= swfb_pkg::DATA_W'($urandom_range(255));
			@(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.mode <= item.mode;
		req_bus.addr <= item.addr;
		req_bus.wdata <= item.wdata;
		@(posedge clk);
		while (!req_bus.ready) @(posedge clk);
		pending_frames.push_back(build_frame(item, device_id_shadow));
	endtask

	// stop sending and wait for every predicted frame to come back
	task automatic drain_requests();
		req_bus.valid <= 1'b0;
		wait (pending_frames.size() == 0);
		repeat (3) @(posedge clk);
	endtask

	// device id write, only with the core idle
	task automatic write_device_id(input logic [swfb_pkg::DEV_W-1:0] dev_id);
		drain_requests();
		cfg_bus.valid <= 1'b1;
		cfg_bus.data <= dev_id;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		device_id_shadow = dev_id;
		cfg_bus.valid <= 1'b0;
	endtask

	// frames under the reset device id
	task automatic test_reset_device_id();
		send_request(make_request(swfb_pkg::MODE_READ, 5'd5, 8'h00));
		send_request(make_request(swfb_pkg::MODE_WRITE, 5'd5, 8'h3c));
		drain_requests();
	endtask

	// address and data extremes, read data ignored
	task automatic test_field_extremes();
		send_request(make_request(swfb_pkg::MODE_READ, 5'd0, 8'h00));
		send_request(make_request(swfb_pkg::MODE_READ, 5'd31, 8'hff));
		send_request(make_request(swfb_pkg::MODE_READ, 5'd21, 8'haa));
		send_request(make_request(swfb_pkg::MODE_WRITE, 5'd0, 8'h00));
		send_request(make_request(swfb_pkg::MODE_WRITE, 5'd31, 8'hff));
		send_request(make_request(swfb_pkg::MODE_WRITE, 5'd0, 8'h80));
		send_request(make_request(swfb_pkg::MODE_WRITE, 5'd31, 8'h01));
		send_request(make_request(swfb_pkg::MODE_WRITE, 5'd10, 8'h55));
		send_request(make_request(swfb_pkg::MODE_WRITE, 5'd21, 8'haa));
		drain_requests();
	endtask

	// device id extremes and one value in between
	task automatic test_device_id_sweep();
		logic [swfb_pkg::DEV_W-1:0] ids[3];
		ids = '{4'd0, 4'd15, 4'd9};
		foreach (ids[i]) begin
			write_device_id(ids[i]);
			send_request(make_request(swfb_pkg::MODE_READ, 5'd31, 8'h5a));
			send_request(make_request(swfb_pkg::MODE_WRITE, 5'd0, 8'hff));
		end
		drain_requests();
	endtask

	// random traffic under four idle and stall mixes, new device id per phase
	task automatic test_random_traffic();
		int idle_mix[4];
		int stall_mix[4];
		idle_mix = '{0, 80, 0, 22};
		stall_mix = '{0, 0, 80, 22};
		foreach (idle_mix[p]) begin
			write_device_id(swfb_pkg::DEV_W'($urandom_range(15)));
			send_idle_pct = idle_mix[p];
			recv_stall_pct = stall_mix[p];
			repeat (PHASE_ITEMS) send_request(random_request());
			drain_requests();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	// response beats checked against the oldest prediction, random stalls
	always @(posedge clk) begin
		swfb_pkg::rsp_t want;
		if (rsp_bus.valid && rsp_bus.ready) begin
			if (pending_frames.size() == 0) begin
				$error("unexpected frame %08h", rsp_bus.frame);
				mismatch_count++;
			end else begin
				want = pending_frames.pop_front();
				if (rsp_bus.frame !== want.frame) begin
					$error("frame: expected %08h, got %08h", want.frame, rsp_bus.frame);
					mismatch_count++;
				end
				if (rsp_bus.header_check !== want.header_check) begin
					$error("header_check: expected %02h, got %02h", want.header_check,
						rsp_bus.header_check);
					mismatch_count++;
				end
				if (rsp_bus.data_check !== want.data_check) begin
					$error("data_check: expected %01h, got %01h", want.data_check,
						rsp_bus.data_check);
					mismatch_count++;
				end
			end
		end
		rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog on cycles with no beat on any channel
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
				|| (cfg_bus.valid && cfg_bus.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("single_wire_bus_frame_builder_core regression: fail");
		$finish;
	end

	// reset, then the tests in turn
	initial begin
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.mode = swfb_pkg::MODE_READ;
		req_bus.addr = '0;
		req_bus.wdata = '0;
		rsp_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_device_id();
		test_field_extremes();
		test_device_id_sweep();
		test_random_traffic();

		drain_requests();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("single_wire_bus_frame_builder_core regression: pass");
		end else begin
			$display("single_wire_bus_frame_builder_core regression: fail");
		end
		$finish;
	end

endmodule
